>>> rtl/mcfl_pkg.sv
// Shared types and constants of the CFL maximum tracker.
// Used by every module of the block; depends on nothing.
`default_nettype none

package mcfl_pkg;

   // Request and response bus layout.
   localparam int ReqDataW = 120;
   localparam int ReqUserW = 4;
   localparam int RspDataW = 48;

   // Field widths.
   localparam int CompW    = 32;
   localparam int OrderW   = 6;
   localparam int IdFieldW = 16;
   localparam int CflW     = 32;
   localparam int ProdW    = 64;
   localparam int PeakW    = 64;
   localparam int RootW    = 32;
   localparam int KW       = 12;
   localparam int ScaledW  = 44;

   // Iteration counts of the serial units.
   localparam int SqrtSteps = 32;
   localparam int DivSteps  = 3;
   localparam int StepW     = 6;

   // Divide by five, one 16-bit quotient digit per step. A digit step divides a value
   // below 5 * 2^16 by multiplying with ceil(2^21 / 5) and dropping 21 bits.
   localparam int DigitW     = 16;
   localparam int DivW       = 48;
   localparam int DivTW      = DigitW + 3;
   localparam int DivProdW   = 2 * DivTW;
   localparam int RecipShift = 21;
   localparam logic [DivTW-1:0] RecipFive = 19'h66667;

   // Defaults of the top level parameters.
   localparam int IdBits     = 16;
   localparam int QueueDepth = 2;

   // Command codes.
   localparam logic CmdLoad   = 1'b0;
   localparam logic CmdSample = 1'b1;

   // Metric row codes.
   localparam logic [1:0] RowR = 2'd0;
   localparam logic [1:0] RowS = 2'd1;
   localparam logic [1:0] RowT = 2'd2;

   // Divisor of the final scaling (0.2 taken as 1/5).
   localparam logic [3:0] ScaleDiv = 4'd5;

   // One classified request as it travels from the front end to the engine.
   typedef struct packed {
      logic                    is_load;
      logic [1:0]              row;
      logic signed [CompW-1:0] comp_a;
      logic signed [CompW-1:0] comp_b;
      logic signed [CompW-1:0] comp_c;
      logic [OrderW-1:0]       order;
      logic                    eoe;
      logic                    eod;
   } cmd_type;

   // Engine to finishing unit.
   typedef struct packed {
      logic              start;
      logic [PeakW-1:0]  peak;
      logic [OrderW-1:0] order;
   } fin_req_type;

   // Finishing unit to engine.
   typedef struct packed {
      logic            done;
      logic [CflW-1:0] est;
   } fin_rsp_type;

endpackage

`default_nettype wire

>>> rtl/mcfl_front.sv
// Front end of the CFL maximum tracker: takes requests, decodes and classifies them.
// Depends on mcfl_pkg; feeds mcfl_queue.
`default_nettype none

module mcfl_front import mcfl_pkg::*; #(
   parameter int ID_W = IdBits
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   input  wire logic [ReqDataW-1:0] req_tdata,
   input  wire logic [ReqUserW-1:0] req_tuser,
   input  wire logic                req_tlast,
   output logic                     q_push,
   output cmd_type                  q_cmd,
   output logic [ID_W-1:0]          q_id,
   input  wire logic                q_ready
);

   logic            valid_ff, valid_in;
   cmd_type         cmd_ff, cmd_in;
   logic [ID_W-1:0] id_ff, id_in;
   logic            accept;
   logic            keep;
   logic [1:0]      row;
   logic            command;
   logic [IdFieldW-1:0] element_id;

   assign command    = req_tuser[0];
   assign row        = req_tuser[2:1];
   assign element_id = req_tdata[117:102];

   assign req_tready = !valid_ff || q_ready;
   assign accept     = req_tvalid && req_tready;
   assign q_push     = valid_ff && q_ready;
   assign q_cmd      = cmd_ff;
   assign q_id       = id_ff;

   // A load of a row that does not exist changes nothing and is dropped here.
   assign keep = (command == CmdSample) || (row inside {RowR, RowS, RowT});

   always_comb begin
      valid_in = valid_ff;
      cmd_in   = cmd_ff;
      id_in    = id_ff;
      if (q_push) begin
         valid_in = 1'b0;
      end
      if (accept && keep) begin
         valid_in       = 1'b1;
         cmd_in.is_load = (command == CmdLoad);
         cmd_in.row     = row;
         cmd_in.comp_a  = req_tdata[31:0];
         cmd_in.comp_b  = req_tdata[63:32];
         cmd_in.comp_c  = req_tdata[95:64];
         cmd_in.order   = req_tdata[101:96];
         cmd_in.eod     = req_tuser[3];
         // The end of the domain also closes the element.
         cmd_in.eoe     = req_tlast || req_tuser[3];
         id_in          = element_id[ID_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      cmd_ff <= cmd_in;
      id_ff  <= id_in;
   end

endmodule

`default_nettype wire

>>> rtl/mcfl_queue.sv
// Short first-in first-out queue between the front end and the engine.
// Depends on mcfl_pkg for its default depth.
`default_nettype none

module mcfl_queue import mcfl_pkg::*; #(
   parameter int WIDTH = 8,
   parameter int DEPTH = QueueDepth
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  ready,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      pop_data,
   output logic                  valid
);

   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]  count_ff, count_in;
   logic             do_push, do_pop;

   assign ready    = (count_ff != CntW'(DEPTH));
   assign valid    = (count_ff != '0);
   assign do_push  = push && ready;
   assign do_pop   = pop && valid;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

>>> rtl/mcfl_finish.sv
// Per-element finishing unit: integer square root, order and time step scaling, divide by five.
// Depends on mcfl_pkg; started by mcfl_back.
`default_nettype none

module mcfl_finish import mcfl_pkg::*; (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic [CflW-1:0] time_step,
   input  wire fin_req_type     fin_req,
   output fin_rsp_type          fin_rsp
);

   localparam logic [2:0] F_IDLE = 3'd0;
   localparam logic [2:0] F_SQRT = 3'd1;
   localparam logic [2:0] F_KMUL = 3'd2;
   localparam logic [2:0] F_TLO  = 3'd3;
   localparam logic [2:0] F_THI  = 3'd4;
   localparam logic [2:0] F_SUMZ = 3'd5;
   localparam logic [2:0] F_DIV  = 3'd6;
   localparam logic [2:0] F_DONE = 3'd7;

   logic [2:0]          state_ff, state_in;
   logic [StepW-1:0]    step_ff, step_in;
   logic [PeakW-1:0]    x_ff, x_in;
   logic [RootW+1:0]    rem_ff, rem_in;
   logic [RootW-1:0]    root_ff, root_in;
   logic [KW-1:0]       k_ff, k_in;
   logic [ScaledW-1:0]  a_ff, a_in;
   logic [ProdW-1:0]    plo_ff, plo_in;
   logic [ScaledW-1:0]  phi_ff, phi_in;
   logic [DivW-1:0]     z_ff, z_in;
   logic [DivW-1:0]     q_ff, q_in;
   logic [2:0]          r5_ff, r5_in;
   logic [RootW+3:0]    sq_part;
   logic [RootW+3:0]    sq_trial;
   logic [DivTW-1:0]    div_t;
   logic [DivProdW-1:0] div_prod;
   logic [DigitW-1:0]   div_q;
   logic [DivTW-1:0]    div_back;
   logic [OrderW-1:0]   order_m1;

   assign sq_part  = {rem_ff, x_ff[PeakW-1 -: 2]};
   assign sq_trial = {2'b00, root_ff, 2'b01};
   assign order_m1 = fin_req.order - 1'b1;

   // One quotient digit of the divide by five: the running remainder (below five) on top of
   // the next 16 dividend bits, divided by reciprocal multiplication.
   assign div_t    = {r5_ff, z_ff[DivW-1 -: DigitW]};
   assign div_prod = div_t * RecipFive;
   assign div_q    = div_prod[RecipShift +: DigitW];
   assign div_back = {3'b000, div_q} * DivTW'(ScaleDiv);

   assign fin_rsp.done = (state_ff == F_DONE);
   assign fin_rsp.est  = (|q_ff[DivW-1:CflW]) ? '1 : q_ff[CflW-1:0];

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      x_in     = x_ff;
      rem_in   = rem_ff;
      root_in  = root_ff;
      k_in     = k_ff;
      a_in     = a_ff;
      plo_in   = plo_ff;
      phi_in   = phi_ff;
      z_in     = z_ff;
      q_in     = q_ff;
      r5_in    = r5_ff;
      case (state_ff)
         F_IDLE: begin
            if (fin_req.start) begin
               x_in    = fin_req.peak;
               rem_in  = '0;
               root_in = '0;
               step_in = '0;
               // An order count of zero squares minus one, which is one.
               k_in    = (fin_req.order == '0) ? KW'(1) : KW'(order_m1) * KW'(order_m1);
               state_in = F_SQRT;
            end
         end
         F_SQRT: begin
            // Two radicand bits per step, one root bit out.
            x_in = {x_ff[PeakW-3:0], 2'b00};
            if (sq_part >= sq_trial) begin
               rem_in  = (RootW + 2)'(sq_part - sq_trial);
               root_in = {root_ff[RootW-2:0], 1'b1};
            end else begin
               rem_in  = sq_part[RootW+1:0];
               root_in = {root_ff[RootW-2:0], 1'b0};
            end
            step_in = step_ff + 1'b1;
            if (step_ff == StepW'(SqrtSteps - 1)) begin
               state_in = F_KMUL;
            end
         end
         F_KMUL: begin
            a_in     = root_ff * k_ff;
            state_in = F_TLO;
         end
         F_TLO: begin
            plo_in   = a_ff[CflW-1:0] * time_step;
            state_in = F_THI;
         end
         F_THI: begin
            phi_in   = a_ff[ScaledW-1:CflW] * time_step;
            state_in = F_SUMZ;
         end
         F_SUMZ: begin
            // Product shifted down by 32; it always fits in 44 bits.
            z_in     = DivW'(phi_ff + ScaledW'(plo_ff[ProdW-1:CflW]));
            q_in     = '0;
            r5_in    = '0;
            step_in  = '0;
            state_in = F_DIV;
         end
         F_DIV: begin
            z_in    = {z_ff[DivW-DigitW-1:0], {DigitW{1'b0}}};
            q_in    = {q_ff[DivW-DigitW-1:0], div_q};
            r5_in   = 3'(div_t - div_back);
            step_in = step_ff + 1'b1;
            if (step_ff == StepW'(DivSteps - 1)) begin
               state_in = F_DONE;
            end
         end
         F_DONE: begin
            state_in = F_IDLE;
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      step_ff <= step_in;
      x_ff    <= x_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      k_ff    <= k_in;
      a_ff    <= a_in;
      plo_ff  <= plo_in;
      phi_ff  <= phi_in;
      z_ff    <= z_in;
      q_ff    <= q_in;
      r5_ff   <= r5_in;
   end

endmodule

`default_nettype wire

>>> rtl/mcfl_back.sv
// Engine of the CFL maximum tracker: metric matrix, local speed, element peak and best value.
// Depends on mcfl_pkg; takes work from mcfl_queue and hands element ends to mcfl_finish.
`default_nettype none

module mcfl_back import mcfl_pkg::*; #(
   parameter int ID_W = IdBits
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            q_valid,
   input  wire cmd_type         q_cmd,
   input  wire logic [ID_W-1:0] q_id,
   output logic                 q_pop,
   output fin_req_type          fin_req,
   input  wire fin_rsp_type     fin_rsp,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   output logic [CflW-1:0]      rsp_value,
   output logic [ID_W-1:0]      rsp_id
);

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_MUL  = 4'd1;
   localparam logic [3:0] ST_SUM  = 4'd2;
   localparam logic [3:0] ST_SQR  = 4'd3;
   localparam logic [3:0] ST_ACC  = 4'd4;
   localparam logic [3:0] ST_PEAK = 4'd5;
   localparam logic [3:0] ST_FIN  = 4'd6;
   localparam logic [3:0] ST_OUT  = 4'd7;

   logic [3:0]              state_ff, state_in;
   logic [1:0]              row_ff, row_in;
   cmd_type                 cmd_ff, cmd_in;
   logic [ID_W-1:0]         id_ff, id_in;
   logic signed [CompW-1:0] matrix_ff [3][3];
   logic signed [CompW-1:0] matrix_in [3][3];
   logic signed [ProdW-1:0] prod_ff [3];
   logic signed [ProdW-1:0] prod_in [3];
   logic signed [CompW-1:0] lv_ff, lv_in;
   logic [PeakW-1:0]        sq_ff, sq_in;
   logic [PeakW-1:0]        acc_ff, acc_in;
   logic [PeakW-1:0]        peak_ff, peak_in;
   logic [CflW-1:0]         best_ff, best_in;
   logic [ID_W-1:0]         best_id_ff, best_id_in;
   logic                    out_valid_ff, out_valid_in;
   logic [CflW-1:0]         out_value_ff, out_value_in;
   logic [ID_W-1:0]         out_id_ff, out_id_in;
   logic [ProdW+1:0]        dot_sum;
   logic                    dot_ovf;
   logic [PeakW-1:0]        peak_new;

   // Exact floor of the row sum over 2^16: the low 16 bits are simply dropped.
   assign dot_sum = {{2{prod_ff[0][ProdW-1]}}, prod_ff[0]}
                  + {{2{prod_ff[1][ProdW-1]}}, prod_ff[1]}
                  + {{2{prod_ff[2][ProdW-1]}}, prod_ff[2]};
   assign dot_ovf = !((&dot_sum[ProdW+1:47]) || !(|dot_sum[ProdW+1:47]));
   assign peak_new = (acc_ff > peak_ff) ? acc_ff : peak_ff;

   assign q_pop         = (state_ff == ST_IDLE) && q_valid;
   assign fin_req.start = (state_ff == ST_PEAK) && cmd_ff.eoe;
   assign fin_req.peak  = peak_new;
   assign fin_req.order = cmd_ff.order;

   assign rsp_valid = out_valid_ff;
   assign rsp_value = out_value_ff;
   assign rsp_id    = out_id_ff;

   always_comb begin
      state_in     = state_ff;
      row_in       = row_ff;
      cmd_in       = cmd_ff;
      id_in        = id_ff;
      matrix_in    = matrix_ff;
      prod_in      = prod_ff;
      lv_in        = lv_ff;
      sq_in        = sq_ff;
      acc_in       = acc_ff;
      peak_in      = peak_ff;
      best_in      = best_ff;
      best_id_in   = best_id_ff;
      out_valid_in = out_valid_ff;
      out_value_in = out_value_ff;
      out_id_in    = out_id_ff;
      if (out_valid_ff && rsp_ready) begin
         out_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               cmd_in = q_cmd;
               id_in  = q_id;
               if (q_cmd.is_load) begin
                  case (q_cmd.row)
                     RowR, RowS, RowT: begin
                        matrix_in[q_cmd.row][0] = q_cmd.comp_a;
                        matrix_in[q_cmd.row][1] = q_cmd.comp_b;
                        matrix_in[q_cmd.row][2] = q_cmd.comp_c;
                     end
                     default: begin
                     end
                  endcase
               end else begin
                  row_in   = RowR;
                  acc_in   = '0;
                  state_in = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            prod_in[0] = matrix_ff[row_ff][0] * cmd_ff.comp_a;
            prod_in[1] = matrix_ff[row_ff][1] * cmd_ff.comp_b;
            prod_in[2] = matrix_ff[row_ff][2] * cmd_ff.comp_c;
            state_in   = ST_SUM;
         end
         ST_SUM: begin
            if (dot_ovf) begin
               lv_in = dot_sum[ProdW+1] ? {1'b1, {(CompW-1){1'b0}}}
                                        : {1'b0, {(CompW-1){1'b1}}};
            end else begin
               lv_in = dot_sum[47:16];
            end
            state_in = ST_SQR;
         end
         ST_SQR: begin
            sq_in    = lv_ff * lv_ff;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            // Three squares of at most 2^62 each never overflow 64 bits.
            acc_in = acc_ff + sq_ff;
            if (row_ff == RowT) begin
               state_in = ST_PEAK;
            end else begin
               row_in   = row_ff + 1'b1;
               state_in = ST_MUL;
            end
         end
         ST_PEAK: begin
            if (cmd_ff.eoe) begin
               peak_in  = '0;
               state_in = ST_FIN;
            end else begin
               peak_in  = peak_new;
               state_in = ST_IDLE;
            end
         end
         ST_FIN: begin
            if (fin_rsp.done) begin
               if (fin_rsp.est > best_ff) begin
                  best_in    = fin_rsp.est;
                  best_id_in = id_ff;
               end
               state_in = cmd_ff.eod ? ST_OUT : ST_IDLE;
            end
         end
         ST_OUT: begin
            if (!out_valid_ff || rsp_ready) begin
               out_valid_in = 1'b1;
               out_value_in = best_ff;
               out_id_in    = best_id_ff;
               best_in      = '0;
               best_id_in   = '0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         matrix_ff    <= '{default: '0};
         peak_ff      <= '0;
         best_ff      <= '0;
         best_id_ff   <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         matrix_ff    <= matrix_in;
         peak_ff      <= peak_in;
         best_ff      <= best_in;
         best_id_ff   <= best_id_in;
         out_valid_ff <= out_valid_in;
      end
      row_ff       <= row_in;
      cmd_ff       <= cmd_in;
      id_ff        <= id_in;
      prod_ff      <= prod_in;
      lv_ff        <= lv_in;
      sq_ff        <= sq_in;
      acc_ff       <= acc_in;
      out_value_ff <= out_value_in;
      out_id_ff    <= out_id_in;
   end

endmodule

`default_nettype wire

>>> rtl/metric_cfl_max_tracker_core.sv
// Top level of the CFL maximum tracker: front end, queue, engine and finishing unit.
// Depends on mcfl_pkg, mcfl_front, mcfl_queue, mcfl_back and mcfl_finish.
//
//   Channel   Direction  Handshake              Carries
//   req_*     in         req_tvalid/req_tready  metric row loads and velocity samples
//   rsp_*     out        rsp_tvalid/rsp_tready  best CFL estimate of a domain and its element
//   csr_*     in         csr_wr_en              time step, unsigned Q0.32
//
// A row load is done in the state that takes it from the queue. A velocity sample goes from
// that state through, for each of the three metric rows, a state of three 32x32 products, one
// of sum and saturation, one square and one accumulate, then on to the peak update.
// A sample that ends an element then waits on the finishing unit: a 32-step square root,
// three scaling products, a sum, a divide by five in three 16-bit digits and a done state to
// hand the estimate back; a domain end then loads the output register once it is free.
// The front end and a two-entry queue keep taking requests while the engine works; a
// finished result sits in the output register until it is taken.
// Reset clears the matrix, the running peak, the best value and the time step at once.
`default_nettype none

module metric_cfl_max_tracker_core import mcfl_pkg::*; #(
   parameter int ID_BITS     = IdBits,
   parameter int QUEUE_DEPTH = QueueDepth
) (
   input  wire logic                clock,
   input  wire logic                reset,
   // Time step register write.
   input  wire logic                csr_wr_en,
   input  wire logic [CflW-1:0]     csr_wr_data,
   // Requests.
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   // comp_a[31:0], comp_b[63:32], comp_c[95:64], poly_order[101:96],
   // element_id[117:102], zero fill[119:118]
   input  wire logic [ReqDataW-1:0] req_tdata,
   // command[0], row_select[2:1], end_of_domain[3]
   input  wire logic [ReqUserW-1:0] req_tuser,
   // end_of_element
   input  wire logic                req_tlast,
   // Results.
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   // cfl_value[31:0], max_element[47:32]
   output logic [RspDataW-1:0]      rsp_tdata
);

   // Element ids are kept at the narrower of the id field and ID_BITS.
   localparam int IdW    = (ID_BITS < IdFieldW) ? ID_BITS : IdFieldW;
   localparam int QueueW = $bits(cmd_type) + IdW;

   logic [CflW-1:0]   time_step_ff, time_step_in;
   logic              f_push;
   cmd_type           f_cmd;
   logic [IdW-1:0]    f_id;
   logic              q_ready;
   logic              q_valid;
   logic              q_pop;
   logic [QueueW-1:0] q_data;
   cmd_type           b_cmd;
   logic [IdW-1:0]    b_id;
   fin_req_type       fin_req;
   fin_rsp_type       fin_rsp;
   logic [CflW-1:0]   rsp_value;
   logic [IdW-1:0]    rsp_id;

   assign time_step_in = csr_wr_en ? csr_wr_data : time_step_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         time_step_ff <= '0;
      end else begin
         time_step_ff <= time_step_in;
      end
   end

   // Front end decodes the bus, folds the domain end into the element end and drops
   // loads of a row that does not exist.
   mcfl_front #(
      .ID_W (IdW)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .q_push     (f_push),
      .q_cmd      (f_cmd),
      .q_id       (f_id),
      .q_ready    (q_ready)
   );

   mcfl_queue #(
      .WIDTH (QueueW),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (f_push),
      .push_data ({f_id, f_cmd}),
      .ready     (q_ready),
      .pop       (q_pop),
      .pop_data  (q_data),
      .valid     (q_valid)
   );

   assign b_cmd = q_data[$bits(cmd_type)-1:0];
   assign b_id  = q_data[QueueW-1:$bits(cmd_type)];

   // Engine: matrix, local speeds, element peak, best value and the output register.
   mcfl_back #(
      .ID_W (IdW)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_cmd     (b_cmd),
      .q_id      (b_id),
      .q_pop     (q_pop),
      .fin_req   (fin_req),
      .fin_rsp   (fin_rsp),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_value (rsp_value),
      .rsp_id    (rsp_id)
   );

   // Square root and scaling, once per element.
   mcfl_finish u_finish (
      .clock     (clock),
      .reset     (reset),
      .time_step (time_step_ff),
      .fin_req   (fin_req),
      .fin_rsp   (fin_rsp)
   );

   assign rsp_tdata = {IdFieldW'(rsp_id), rsp_value};

endmodule

`default_nettype wire

>>> verif/tb_metric_cfl_max_tracker_core.sv
// Self-checking testbench for metric_cfl_max_tracker_core: directed and random request streams
// checked against a bit-exact predictor of the domain CFL maximum. Depends on mcfl_pkg and the
// RTL of the tracker core; needs no other file.
`timescale 1ns / 1ps

module tb_metric_cfl_max_tracker_core import mcfl_pkg::*; ();

   // Row code that selects no metric row; a load with it is dropped by the block.
   localparam logic [1:0] RowNone = 2'd3;

   // Cycles to let pass after the last expected result before touching the time step.
   // Up to four requests (front end, two queue entries, engine) can still be in flight with no
   // result pending, each taking longest when it ends an element.
   localparam int unsigned SettleCycles = 600;

   // Run limit. The slowest correct run is about 1700 requests, each ending an element behind
   // the longest sender gap and receiver stall, plus the hold-off of the backpressure test and
   // the settling waits. The limit takes that about six times over.
   localparam int unsigned CycleLimit = 1_500_000;

   // One request as the sender sees it, before packing onto the stream bus.
   typedef struct packed {
      logic                    cmd;
      logic [1:0]              row;
      logic signed [CompW-1:0] a;
      logic signed [CompW-1:0] b;
      logic signed [CompW-1:0] c;
      logic [OrderW-1:0]       order;
      logic [IdFieldW-1:0]     id;
      logic                    eoe;
      logic                    eod;
   } req_item_type;

   // The result of one domain: best estimate and the element it came from.
   typedef struct packed {
      logic [IdFieldW-1:0] elem;
      logic [CflW-1:0]     cfl;
   } domain_result_type;

   logic                clock       = 1'b0;
   logic                reset       = 1'b1;
   logic                csr_wr_en   = 1'b0;
   logic [CflW-1:0]     csr_wr_data = '0;
   logic                req_tvalid  = 1'b0;
   logic                req_tready;
   logic [ReqDataW-1:0] req_tdata   = '0;
   logic [ReqUserW-1:0] req_tuser   = '0;
   logic                req_tlast   = 1'b0;
   logic                rsp_tvalid;
   logic                rsp_tready  = 1'b0;
   logic [RspDataW-1:0] rsp_tdata;

   // Predictor state, a private copy of what the block holds.
   logic signed [CompW-1:0] pred_metric [9];
   logic [PeakW-1:0]        pred_peak_sq;
   logic [CflW-1:0]         pred_best_cfl;
   logic [IdFieldW-1:0]     pred_best_elem;
   logic [CflW-1:0]         pred_step;

   domain_result_type expected_domain_results [$];

   int unsigned cycle_count      = 0;
   int unsigned error_count      = 0;
   int unsigned requests_sent    = 0;
   bit          src_idle_en      = 1'b1;
   bit          sink_idle_en     = 1'b1;
   int unsigned sink_hold_cycles = 0;

   metric_cfl_max_tracker_core i_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------------------------------

   // One row of the mapping applied to (u, v, w). The three Q16.16 products are summed exactly
   // and floored by one arithmetic shift, which equals summing the floored parts and their
   // fractions separately. The result saturates to the signed 32-bit range.
   function automatic logic signed [CompW-1:0] local_speed(input int row,
         input logic signed [CompW-1:0] u, input logic signed [CompW-1:0] v,
         input logic signed [CompW-1:0] w);
      logic signed [65:0] pa, pb, pc, acc;
      pa  = pred_metric[row * 3 + 0] * u;
      pb  = pred_metric[row * 3 + 1] * v;
      pc  = pred_metric[row * 3 + 2] * w;
      acc = (pa + pb + pc) >>> 16;
      if (acc > 66'sh0_7FFF_FFFF)
         return 32'sh7FFF_FFFF;
      if (acc < -66'sh0_8000_0000)
         return 32'sh8000_0000;
      return acc[CompW-1:0];
   endfunction

   // Floor of the integer square root, one result bit per pair of input bits.
   function automatic logic [RootW-1:0] int_sqrt(input logic [PeakW-1:0] x);
      logic [63:0] r, probe;
      r     = '0;
      probe = 64'h4000_0000_0000_0000;
      while (probe > x)
         probe = probe >> 2;
      while (probe != 0) begin
         if (x >= r + probe) begin
            x = x - (r + probe);
            r = (r >> 1) + probe;
         end else begin
            r = r >> 1;
         end
         probe = probe >> 2;
      end
      return r[RootW-1:0];
   endfunction

   // sqrt(peak) * (order - 1)^2 * dt / 5. The time step is split in halves so that every
   // partial product stays inside 64 bits; an order count of zero gives a factor of one.
   function automatic logic [CflW-1:0] element_cfl(input logic [OrderW-1:0] order);
      logic [63:0] k, a, x, e;
      k = (order == 0) ? 64'd1 : (64'(order) - 64'd1) * (64'(order) - 64'd1);
      a = 64'(int_sqrt(pred_peak_sq)) * k;
      x = a * 64'(pred_step[31:16]) + ((a * 64'(pred_step[15:0])) >> 16);
      e = x / (64'(ScaleDiv) << 16);
      return (e > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : e[CflW-1:0];
   endfunction

   // Advances the predictor by one accepted request; returns 1 with the domain result when
   // the request closes a domain.
   function automatic bit predict_domain_result(input req_item_type it,
         output domain_result_type res);
      logic signed [63:0] wr, ws, wt;
      logic [PeakW-1:0]   sq;
      logic [CflW-1:0]    est;
      int                 base;
      res = '0;
      if (it.cmd == CmdLoad) begin
         // Flags on a load mean nothing, and the fourth row code is dropped.
         if (it.row != RowNone) begin
            base = it.row * 3;
            pred_metric[base + 0] = it.a;
            pred_metric[base + 1] = it.b;
            pred_metric[base + 2] = it.c;
         end
         return 1'b0;
      end
      wr = local_speed(RowR, it.a, it.b, it.c);
      ws = local_speed(RowS, it.a, it.b, it.c);
      wt = local_speed(RowT, it.a, it.b, it.c);
      sq = 64'(wr * wr) + 64'(ws * ws) + 64'(wt * wt);
      if (sq > pred_peak_sq)
         pred_peak_sq = sq;
      // The end of a domain also closes its element.
      if (it.eoe || it.eod) begin
         est = element_cfl(it.order);
         if (est > pred_best_cfl) begin
            pred_best_cfl  = est;
            pred_best_elem = it.id;
         end
         pred_peak_sq = '0;
      end
      if (it.eod) begin
         res.cfl        = pred_best_cfl;
         res.elem       = pred_best_elem;
         pred_best_cfl  = '0;
         pred_best_elem = '0;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // ------------------------------------------------------------------------------------------
   // Request construction
   // ------------------------------------------------------------------------------------------

   function automatic logic [ReqDataW-1:0] pack_request_data(input req_item_type it);
      return {2'b00, it.id, it.order, it.c, it.b, it.a};
   endfunction

   // Mostly short gaps, now and then a long one.
   function automatic int unsigned idle_len();
      if ($urandom_range(0, 19) == 0)
         return $urandom_range(12, 40);
      return $urandom_range(1, 3);
   endfunction

   // Q16.16 values: full range, values within plus or minus three, tiny fractions, and the corners.
   function automatic logic [CompW-1:0] rand_q16();
      logic [CompW-1:0] mag;
      case ($urandom_range(0, 5))
         0, 1: return $urandom;
         2, 3: begin
            mag = $urandom_range(0, 32'h0003_0000);
            return ($urandom_range(0, 1) != 0) ? -mag : mag;
         end
         4: begin
            mag = $urandom_range(0, 32'h0000_0FFF);
            return ($urandom_range(0, 1) != 0) ? -mag : mag;
         end
         default: begin
            case ($urandom_range(0, 4))
               0:       return 32'h7FFF_FFFF;
               1:       return 32'h8000_0000;
               2:       return 32'h0001_0000;
               3:       return 32'hFFFF_0000;
               default: return 32'h0000_0000;
            endcase
         end
      endcase
   endfunction

   // Orders of real elements are 1..32; the whole 6-bit field appears now and then.
   function automatic logic [OrderW-1:0] rand_order();
      if ($urandom_range(0, 7) == 0)
         return 6'($urandom_range(0, 63));
      return 6'($urandom_range(1, 32));
   endfunction

   function automatic req_item_type make_load(input logic [1:0] row, input logic [CompW-1:0] a,
         input logic [CompW-1:0] b, input logic [CompW-1:0] c);
      req_item_type it;
      it.cmd   = CmdLoad;
      it.row   = row;
      it.a     = a;
      it.b     = b;
      it.c     = c;
      it.order = 6'($urandom);
      it.id    = 16'($urandom);
      it.eoe   = 1'b0;
      it.eod   = 1'b0;
      return it;
   endfunction

   function automatic req_item_type make_sample(input logic [CompW-1:0] u,
         input logic [CompW-1:0] v, input logic [CompW-1:0] w,
         input logic [OrderW-1:0] order, input logic [IdFieldW-1:0] id,
         input logic eoe, input logic eod);
      req_item_type it;
      it.cmd   = CmdSample;
      it.row   = 2'($urandom);
      it.a     = u;
      it.b     = v;
      it.c     = w;
      it.order = order;
      it.id    = id;
      it.eoe   = eoe;
      it.eod   = eod;
      return it;
   endfunction

   // Anything the fields allow, including stray domain ends and dropped loads.
   function automatic req_item_type rand_noise();
      req_item_type it;
      it.cmd   = 1'($urandom);
      it.row   = 2'($urandom);
      it.a     = rand_q16();
      it.b     = rand_q16();
      it.c     = rand_q16();
      it.order = 6'($urandom);
      it.id    = 16'($urandom);
      it.eoe   = 1'($urandom);
      it.eod   = ($urandom_range(0, 3) == 0);
      return it;
   endfunction

   // ------------------------------------------------------------------------------------------
   // Shared driving tasks
   // ------------------------------------------------------------------------------------------

   task automatic report_mismatch(input string what);
      error_count++;
      $display("mismatch at cycle %0d: %s", cycle_count, what);
   endtask

   // Offers one request and waits for its handshake. The valid stays high between
   // back-to-back requests, so it is only ever written once per time step.
   task automatic send_request(input req_item_type it);
      domain_result_type res;
      int unsigned       gap;
      gap = (src_idle_en && $urandom_range(0, 3) == 0) ? idle_len() : 0;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= pack_request_data(it);
      req_tuser  <= {it.eod, it.row, it.cmd};
      req_tlast  <= it.eoe;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      if (predict_domain_result(it, res))
         expected_domain_results.push_back(res);
      if (!(it.cmd == CmdLoad && it.row == RowNone))
         requests_sent++;
   endtask

   // Drops the valid and waits until every expected result is in, then lets the requests
   // that produce no result work their way out of the engine and the finishing unit.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (expected_domain_results.size() != 0)
         @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_time_step(input logic [CflW-1:0] value);
      wait_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      pred_step    = value;
   endtask

   task automatic load_identity();
      send_request(make_load(RowR, 32'h0001_0000, 32'h0000_0000, 32'h0000_0000));
      send_request(make_load(RowS, 32'h0000_0000, 32'h0001_0000, 32'h0000_0000));
      send_request(make_load(RowT, 32'h0000_0000, 32'h0000_0000, 32'h0001_0000));
   endtask

   // A well-formed domain: one to four elements, each usually with fresh geometry loaded from a
   // random first row in turn, then one to six samples closing with the element flag. The last
   // element sometimes ends on the domain flag alone. A stray request now and then.
   task automatic send_random_domain();
      int unsigned         n_elem, n_pts, first_row;
      logic [IdFieldW-1:0] id;
      logic [OrderW-1:0]   order;
      bit                  last_elem, last_pt;
      n_elem = $urandom_range(1, 4);
      for (int e = 0; e < n_elem; e++) begin
         id    = 16'($urandom);
         order = rand_order();
         if ($urandom_range(0, 3) != 0) begin
            first_row = $urandom_range(0, 2);
            for (int r = 0; r < 3; r++)
               send_request(make_load(2'((first_row + r) % 3), rand_q16(), rand_q16(),
                                      rand_q16()));
         end
         n_pts = $urandom_range(1, 6);
         for (int p = 0; p < n_pts; p++) begin
            if ($urandom_range(0, 15) == 0)
               send_request(rand_noise());
            last_elem = (e == n_elem - 1);
            last_pt   = (p == n_pts - 1);
            send_request(make_sample(rand_q16(), rand_q16(), rand_q16(), order, id,
                                     last_pt && !(last_elem && $urandom_range(0, 4) == 0),
                                     last_elem && last_pt));
         end
      end
   endtask

   // ------------------------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------------------------

   // Straight out of reset the matrix and the time step are zero, so a lone domain end
   // must report a zero estimate for element zero.
   task automatic test_reset_state();
      send_request(make_sample(rand_q16(), rand_q16(), rand_q16(), rand_order(),
                               16'($urandom), 1'b0, 1'b1));
   endtask

   // Field corners at the largest time step: saturating local speeds, saturating estimates,
   // a tie on the saturated value, order counts of zero and one, ignored loads, and a
   // domain that ends without its element flag.
   task automatic test_field_extremes();
      req_item_type it;
      write_time_step(32'hFFFF_FFFF);
      load_identity();
      // A load on the unused row code with both flags set must change nothing.
      it     = make_load(RowNone, 32'hDEAD_BEEF, 32'h8000_0000, 32'h7FFF_FFFF);
      it.eoe = 1'b1;
      it.eod = 1'b1;
      send_request(it);
      // Flags on a real load are ignored too.
      it     = make_load(RowR, 32'h0001_0000, 32'h0000_0000, 32'h0000_0000);
      it.eoe = 1'b1;
      it.eod = 1'b1;
      send_request(it);
      send_request(make_sample(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 6'd32,
                               16'hFFFF, 1'b1, 1'b0));
      send_request(make_sample(32'h0000_0001, 32'h0000_0001, 32'h0000_0001, 6'd1,
                               16'h0001, 1'b1, 1'b0));
      send_request(make_sample(32'h0003_0000, 32'hFFFD_0000, 32'h0000_8000, 6'd0,
                               16'h00AA, 1'b1, 1'b0));
      send_request(make_sample(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 6'd2,
                               16'h0000, 1'b0, 1'b1));
      // Every product at its corner: both saturation directions of the local speed.
      send_request(make_load(RowR, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
      send_request(make_load(RowS, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
      send_request(make_load(RowT, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000));
      send_request(make_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 6'd63,
                               16'h5A5A, 1'b1, 1'b0));
      // Same saturated estimate again: the first element must stay the best.
      send_request(make_sample(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 6'd63,
                               16'hA5A5, 1'b1, 1'b1));
      // The next domain starts from nothing.
      send_request(make_sample(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 6'd63,
                               16'h1111, 1'b1, 1'b1));
   endtask

   // Two elements with equal, unsaturated estimates: only a strictly larger one replaces
   // the best, so the first id is reported.
   task automatic test_strict_tie();
      write_time_step(32'h8000_0000);
      load_identity();
      send_request(make_sample(32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 6'd3,
                               16'h0101, 1'b1, 1'b0));
      send_request(make_sample(32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 6'd3,
                               16'h0202, 1'b1, 1'b0));
      send_request(make_sample(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 6'd3,
                               16'h0303, 1'b1, 1'b1));
   endtask

   // Random well-formed domains at one time step, with idling switched on and off per domain
   // so that some stretches run at full rate.
   task automatic test_random_phase(input logic [CflW-1:0] step, input int unsigned count);
      int unsigned stop_at;
      write_time_step(step);
      stop_at = requests_sent + count;
      while (requests_sent < stop_at) begin
         src_idle_en  = ($urandom_range(0, 3) != 0);
         sink_idle_en = ($urandom_range(0, 3) != 0);
         send_random_domain();
      end
   endtask

   // The receiver holds off for a long stretch while a run of one-sample domains is offered
   // at full rate: the output register fills, the engine waits, the queue fills and the
   // request channel must stall without losing anything.
   task automatic test_backpressure();
      wait_idle();
      src_idle_en      = 1'b0;
      sink_hold_cycles = 2500;
      load_identity();
      repeat (12)
         send_request(make_sample(rand_q16(), rand_q16(), rand_q16(), rand_order(),
                                  16'($urandom), 1'b1, 1'b1));
   endtask

   // ------------------------------------------------------------------------------------------
   // Processes
   // ------------------------------------------------------------------------------------------

   // Receiver: random stalls of random length, or one long counted hold-off on request.
   // Each pass writes rsp_tready once and then covers as many edges as the stall lasts.
   initial begin : rsp_sink
      int unsigned hold;
      forever begin
         @(posedge clock);
         if (sink_hold_cycles != 0) begin
            hold             = sink_hold_cycles;
            sink_hold_cycles = 0;
            rsp_tready <= 1'b0;
            repeat (hold - 1) @(posedge clock);
         end else if (sink_idle_en && $urandom_range(0, 3) == 0) begin
            hold = idle_len();
            rsp_tready <= 1'b0;
            repeat (hold - 1) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Every accepted result is compared with the oldest expected domain result.
   always @(posedge clock) begin : rsp_check
      domain_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_domain_results.size() == 0) begin
            report_mismatch($sformatf("result %h with none expected", rsp_tdata));
         end else begin
            want = expected_domain_results.pop_front();
            if (rsp_tdata[CflW-1:0] !== want.cfl)
               report_mismatch($sformatf("cfl_value %h, expected %h",
                                         rsp_tdata[CflW-1:0], want.cfl));
            if (rsp_tdata[CflW +: IdFieldW] !== want.elem)
               report_mismatch($sformatf("max_element %h, expected %h",
                                         rsp_tdata[CflW +: IdFieldW], want.elem));
         end
      end
   end

   // A hung block or a lost result ends the run here.
   initial begin : watchdog
      while (cycle_count < CycleLimit) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAILURE");
      $finish;
   end

   initial begin
      foreach (pred_metric[i])
         pred_metric[i] = '0;
      pred_peak_sq   = '0;
      pred_best_cfl  = '0;
      pred_best_elem = '0;
      pred_step      = '0;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_field_extremes();
      test_strict_tie();
      test_random_phase(32'hFFFF_FFFF, 330);
      test_random_phase(32'h0000_0001, 280);
      test_random_phase(32'($urandom), 330);
      test_backpressure();
      test_random_phase(32'h0083_126F, 330);
      test_random_phase(32'h0000_0000, 150);
      test_random_phase(32'($urandom_range(1, 32'h00FF_FFFF)), 150);

      wait_idle();
      if (error_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
